FILE: rtl/kct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kct_pkg: shared types and constants for the keyed count table
// Table geometry, key and count types, operation codes and the table write
// request that passes between the sequencer and the storage.
// ----------------------------------------------------------------------------
package kct_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int KEY_BITS      = 16;
    localparam int COUNT_BITS    = 16;

    localparam int IN_KEY_BITS   = 16;
    localparam int AMOUNT_BITS   = 16;
    localparam int OUT_CNT_BITS  = 16;

    localparam int IDX_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SUM_BITS = ((COUNT_BITS > AMOUNT_BITS) ? COUNT_BITS : AMOUNT_BITS) + 1;

    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TABLE_ENTRIES - 1);

    typedef logic [KEY_BITS-1:0]    t_key;
    typedef logic [COUNT_BITS-1:0]  t_cnt;
    typedef logic [IDX_BITS-1:0]    t_idx;
    typedef logic [AMOUNT_BITS-1:0] t_amount;
    typedef logic [SUM_BITS-1:0]    t_sum;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_LOOKUP = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic en;
        logic used;
        t_idx addr;
        t_key key;
        t_cnt cnt;
    } t_tbl_wr;

    function automatic t_key key_of(input logic [IN_KEY_BITS-1:0] k);
        t_key r;
        for (int i = 0; i < KEY_BITS; i++) begin
            r[i] = (i < IN_KEY_BITS) ? k[i] : 1'b0;
        end
        return r;
    endfunction

    function automatic logic [OUT_CNT_BITS-1:0] cnt_out(input t_cnt c);
        logic [OUT_CNT_BITS-1:0] r;
        for (int i = 0; i < OUT_CNT_BITS; i++) begin
            r[i] = (i < COUNT_BITS) ? c[i] : 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/keyed_count_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_count_table_core: table of unique keys with saturating counts
// Add, remove and lookup requests on a small associative count table.
// ----------------------------------------------------------------------------
// One request is taken at a time; o_in_stall is high from acceptance until the
// result has been placed in the output register. A request with key 0 or an
// unused mode skips the scan and goes straight to the write-back step.
// Otherwise a single key comparator walks the slots one per cycle, stopping
// at the first match or after the last slot. The write-back step reads the
// slot, runs the count update unit and, where the request changes the slot,
// writes it back. A pending result in the output register does not block the
// next request, only the write-back step.
module keyed_count_table_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [15:0] i_item_key,
    input  wire logic [15:0] i_amount,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_ok,
    output logic [15:0]      o_count_after
);
    import kct_pkg::*;

    t_state  r_state, n_state;
    t_mode   r_mode, n_mode;
    t_key    r_key, n_key;
    t_amount r_amount, n_amount;
    logic    r_skip, n_skip;
    t_idx    r_idx, n_idx;
    logic    r_found, n_found;
    t_idx    r_hit, n_hit;
    logic    r_free_ok, n_free_ok;
    t_idx    r_free, n_free;
    logic    r_out_valid, n_out_valid;
    logic    r_ok, n_ok;
    logic [OUT_CNT_BITS-1:0] r_cnt, n_cnt;

    t_idx    w_rd_addr;
    logic    w_rd_used;
    t_key    w_rd_key;
    t_cnt    w_rd_cnt;
    t_tbl_wr w_wr;
    t_cnt    w_alu_in;
    t_cnt    w_alu_cnt;
    logic    w_alu_empty;
    logic    w_accept;
    logic    w_out_free;
    logic    w_hit;

    kct_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_rd_addr),
        .i_wr      (w_wr),
        .o_rd_used (w_rd_used),
        .o_rd_key  (w_rd_key),
        .o_rd_cnt  (w_rd_cnt)
    );

    kct_alu u_alu (
        .i_remove (r_mode == MODE_REMOVE),
        .i_cnt    (w_alu_in),
        .i_amount (r_amount),
        .o_cnt    (w_alu_cnt),
        .o_empty  (w_alu_empty)
    );

    assign o_in_stall    = (r_state != S_IDLE);
    assign w_accept      = i_in_valid && (r_state == S_IDLE);
    assign w_out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_ok;
    assign o_count_after = r_cnt;

    assign w_rd_addr = (r_state == S_SCAN) ? r_idx : (r_found ? r_hit : r_free);
    assign w_hit     = w_rd_used && (w_rd_key == r_key);
    assign w_alu_in  = r_found ? w_rd_cnt : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_key     <= n_key;
        r_amount  <= n_amount;
        r_skip    <= n_skip;
        r_idx     <= n_idx;
        r_found   <= n_found;
        r_hit     <= n_hit;
        r_free_ok <= n_free_ok;
        r_free    <= n_free;
        r_ok      <= n_ok;
        r_cnt     <= n_cnt;
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_key       = r_key;
        n_amount    = r_amount;
        n_skip      = r_skip;
        n_idx       = r_idx;
        n_found     = r_found;
        n_hit       = r_hit;
        n_free_ok   = r_free_ok;
        n_free      = r_free;
        n_out_valid = r_out_valid && i_out_stall;
        n_ok        = r_ok;
        n_cnt       = r_cnt;
        w_wr        = '0;
        w_wr.key    = r_key;
        w_wr.cnt    = w_alu_cnt;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_key     = key_of(i_item_key);
                    n_amount  = i_amount;
                    n_mode    = t_mode'(i_mode);
                    n_skip    = (key_of(i_item_key) == '0) || (i_mode > MODE_LOOKUP);
                    n_idx     = '0;
                    n_found   = 1'b0;
                    n_free_ok = 1'b0;
                    n_state   = n_skip ? S_EXEC : S_SCAN;
                end
            end
            S_SCAN: begin
                if (!w_rd_used && !r_free_ok) begin
                    n_free_ok = 1'b1;
                    n_free    = r_idx;
                end
                if (w_hit) begin
                    n_found = 1'b1;
                    n_hit   = r_idx;
                    n_state = S_EXEC;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_EXEC;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_ok        = 1'b0;
                    n_cnt       = '0;
                    if (!r_skip) begin
                        unique case (r_mode)
                            MODE_ADD: begin
                                if (r_found || r_free_ok) begin
                                    w_wr.en   = 1'b1;
                                    w_wr.used = 1'b1;
                                    w_wr.addr = r_found ? r_hit : r_free;
                                    n_ok      = 1'b1;
                                    n_cnt     = cnt_out(w_alu_cnt);
                                end
                            end
                            MODE_REMOVE: begin
                                if (r_found) begin
                                    w_wr.en   = 1'b1;
                                    w_wr.used = !w_alu_empty;
                                    w_wr.addr = r_hit;
                                    n_ok      = 1'b1;
                                    n_cnt     = cnt_out(w_alu_cnt);
                                end
                            end
                            MODE_LOOKUP: begin
                                if (r_found) begin
                                    n_ok  = 1'b1;
                                    n_cnt = cnt_out(w_rd_cnt);
                                end
                            end
                            default: begin
                                n_ok = 1'b0;
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_wr_only_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> (r_state == S_EXEC && !r_skip))
        else $error("table write outside write-back step");

    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_EXEC)
        else $error("result appeared without a write-back step");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> (o_count_after == '0))
        else $error("failed request carries a nonzero count");

    a_lookup_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_mode == MODE_LOOKUP) |-> !w_wr.en)
        else $error("lookup modified the table");

    a_new_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr.en && w_wr.used && !r_found) |-> !w_rd_used)
        else $error("new key placed in a used slot");

endmodule
`default_nettype wire

FILE: rtl/kct_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kct_table: slot storage
// Per-slot used flags cleared by reset, plus key and count registers that are
// written on demand. One read address, one write request per cycle.
// ----------------------------------------------------------------------------
module kct_table (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire kct_pkg::t_idx   i_rd_addr,
    input  wire kct_pkg::t_tbl_wr i_wr,
    output logic                 o_rd_used,
    output kct_pkg::t_key        o_rd_key,
    output kct_pkg::t_cnt        o_rd_cnt
);
    import kct_pkg::*;

    logic [TABLE_ENTRIES-1:0] r_used;
    t_key                     r_key [TABLE_ENTRIES];
    t_cnt                     r_cnt [TABLE_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_wr.en) begin
            r_used[i_wr.addr] <= i_wr.used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_key[i_wr.addr] <= i_wr.key;
            r_cnt[i_wr.addr] <= i_wr.cnt;
        end
    end

    assign o_rd_used = r_used[i_rd_addr];
    assign o_rd_key  = r_key[i_rd_addr];
    assign o_rd_cnt  = r_cnt[i_rd_addr];

endmodule
`default_nettype wire

FILE: rtl/kct_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kct_alu: count update unit
// Saturating add of the amount, or subtract of max(amount,1) with a flag
// that tells when the count drops to zero or below.
// ----------------------------------------------------------------------------
module kct_alu (
    input  wire logic             i_remove,
    input  wire kct_pkg::t_cnt    i_cnt,
    input  wire kct_pkg::t_amount i_amount,
    output kct_pkg::t_cnt         o_cnt,
    output logic                  o_empty
);
    import kct_pkg::*;

    localparam t_sum COUNT_MAX = SUM_BITS'({COUNT_BITS{1'b1}});

    t_sum w_cnt;
    t_sum w_amt;
    t_sum w_take;
    t_sum w_sum;
    t_sum w_diff;

    always_comb begin
        w_cnt  = SUM_BITS'(i_cnt);
        w_amt  = SUM_BITS'(i_amount);
        w_take = (i_amount == '0) ? SUM_BITS'(1) : w_amt;
        w_sum  = w_cnt + w_amt;
        w_diff = w_cnt - w_take;
        if (i_remove) begin
            o_empty = (w_cnt <= w_take);
            o_cnt   = o_empty ? '0 : COUNT_BITS'(w_diff);
        end else begin
            o_empty = 1'b0;
            o_cnt   = (w_sum > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX) : COUNT_BITS'(w_sum);
        end
    end

endmodule
`default_nettype wire

FILE: tb/keyed_count_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_count_table_checker: request/result monitor for the count table
// Watches both channels of keyed_count_table_core. Each accepted request is
// applied to a local copy of the table, and the result it should give is
// queued. Each accepted result is compared with the oldest queued one.
// ----------------------------------------------------------------------------
module keyed_count_table_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [15:0] i_item_key,
    input  wire logic [15:0] i_amount,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic        i_ok,
    input  wire logic [15:0] i_count_after,
    output int               o_fail_count,
    output int               o_pending
);
    import kct_pkg::*;

    localparam logic [63:0] COUNT_LIMIT = (64'd1 << COUNT_BITS) - 64'd1;

    typedef struct packed {
        logic                    ok;
        logic [OUT_CNT_BITS-1:0] count;
    } t_table_result;

    logic [TABLE_ENTRIES-1:0] slot_taken;
    t_key                     slot_item [TABLE_ENTRIES];
    t_cnt                     slot_total[TABLE_ENTRIES];

    t_table_result expected_results[$];
    t_table_result predicted;
    t_table_result oldest;
    int            failures = 0;

    function automatic t_table_result apply_table_op(input logic [1:0]  mode,
                                                     input logic [15:0] key_in,
                                                     input logic [15:0] amount);
        t_table_result r;
        t_key          key;
        int            hit;
        int            free;
        logic [63:0]   sum;
        logic [63:0]   take;
        key  = t_key'(key_in);
        r    = '0;
        hit  = -1;
        free = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (hit < 0 && slot_taken[i] && slot_item[i] == key) begin
                hit = i;
            end
            if (free < 0 && !slot_taken[i]) begin
                free = i;
            end
        end
        if (key != '0) begin
            case (mode)
                MODE_ADD: begin
                    if (hit >= 0) begin
                        sum = 64'(slot_total[hit]) + 64'(amount);
                        slot_total[hit] = t_cnt'((sum > COUNT_LIMIT) ? COUNT_LIMIT : sum);
                        r.ok    = 1'b1;
                        r.count = OUT_CNT_BITS'(slot_total[hit]);
                    end else if (free >= 0) begin
                        sum = 64'(amount);
                        slot_taken[free] = 1'b1;
                        slot_item[free]  = key;
                        slot_total[free] = t_cnt'((sum > COUNT_LIMIT) ? COUNT_LIMIT : sum);
                        r.ok    = 1'b1;
                        r.count = OUT_CNT_BITS'(slot_total[free]);
                    end
                end
                MODE_REMOVE: begin
                    if (hit >= 0) begin
                        take = (amount == '0) ? 64'd1 : 64'(amount);
                        r.ok = 1'b1;
                        if (64'(slot_total[hit]) <= take) begin
                            slot_taken[hit] = 1'b0;
                        end else begin
                            slot_total[hit] = t_cnt'(64'(slot_total[hit]) - take);
                            r.count = OUT_CNT_BITS'(slot_total[hit]);
                        end
                    end
                end
                MODE_LOOKUP: begin
                    if (hit >= 0) begin
                        r.ok    = 1'b1;
                        r.count = OUT_CNT_BITS'(slot_total[hit]);
                    end
                end
                default: begin
                end
            endcase
        end
        return r;
    endfunction

    task automatic note_failure(input string what);
        failures++;
        if (failures <= 10) begin
            $display("%0t: %s", $realtime, what);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            slot_taken = '0;
            expected_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predicted = apply_table_op(i_mode, i_item_key, i_amount);
                expected_results.push_back(predicted);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("result with no request pending: ok=%0d count=%0d",
                                           i_ok, i_count_after));
                end else begin
                    oldest = expected_results.pop_front();
                    if (oldest.ok !== i_ok || oldest.count !== i_count_after) begin
                        note_failure($sformatf("expected ok=%0d count=%0d, got ok=%0d count=%0d",
                                               oldest.ok, oldest.count, i_ok, i_count_after));
                    end
                end
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= failures + expected_results.size();
    end

endmodule

FILE: tb/keyed_count_table_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_count_table_core_test: top of the count table testbench
// Drives add, remove and lookup requests into keyed_count_table_core, first a
// directed set covering null keys, the unused mode, saturation, freeing and a
// full table, then random requests over a small key pool under three patterns
// of sender idling and receiver stalling. The checker judges every result.
// ----------------------------------------------------------------------------
module keyed_count_table_core_test;

    import kct_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         POOL_SIZE   = 24;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [1:0]  i_mode        = '0;
    logic [15:0] i_item_key    = '0;
    logic [15:0] i_amount      = '0;
    logic        i_out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_ok;
    logic [15:0] o_count_after;

    int          fail_count;
    int          pending;
    int          in_idle_pct   = 0;
    int          out_stall_pct = 0;
    logic [15:0] key_pool[POOL_SIZE];

    always #4 i_clk = ~i_clk;

    keyed_count_table_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_item_key    (i_item_key),
        .i_amount      (i_amount),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_ok          (o_ok),
        .o_count_after (o_count_after)
    );

    keyed_count_table_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_item_key    (i_item_key),
        .i_amount      (i_amount),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_ok          (o_ok),
        .i_count_after (o_count_after),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    task automatic send_request(input logic [1:0]  mode,
                                input logic [15:0] key,
                                input logic [15:0] amount);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_item_key <= key;
        i_amount   <= amount;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_random_request();
        int          pick;
        logic [1:0]  mode;
        logic [15:0] key;
        logic [15:0] amount;
        pick = $urandom_range(99);
        key  = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                         : 16'($urandom);
        case ($urandom_range(9))
            6, 7:    amount = 16'($urandom);
            8:       amount = 16'hffff;
            9:       amount = '0;
            default: amount = 16'($urandom_range(7));
        endcase
        if (pick < 40) begin
            mode = MODE_ADD;
        end else if (pick < 75) begin
            mode = MODE_REMOVE;
        end else if (pick < 95) begin
            mode = MODE_LOOKUP;
        end else if (pick < 97) begin
            mode = MODE_UNUSED;
        end else begin
            mode = 2'($urandom_range(3));
            key  = '0;
        end
        send_request(mode, key, amount);
    endtask

    initial begin
        key_pool[0] = 16'h0001;
        for (int i = 1; i < 16; i++) begin
            key_pool[i] = 16'h8000 | 16'(i + 1);
        end
        for (int i = 16; i < POOL_SIZE; i++) begin
            key_pool[i] = 16'($urandom_range(1, 65535));
        end

        repeat (6) @(posedge i_clk);
        i_rst_n       <= 1'b1;
        in_idle_pct   = 11;
        out_stall_pct <= 75;
        @(posedge i_clk);

        // saturation, remove of one, freeing, absent key
        send_request(MODE_ADD,    16'hffff, 16'hffff);
        send_request(MODE_ADD,    16'hffff, 16'h0001);
        send_request(MODE_REMOVE, 16'hffff, 16'h0000);
        send_request(MODE_REMOVE, 16'hffff, 16'hffff);
        send_request(MODE_LOOKUP, 16'hffff, 16'h0000);
        send_request(MODE_REMOVE, 16'hffff, 16'h0005);
        // null key and unused mode
        send_request(MODE_ADD,    16'h0000, 16'h0010);
        send_request(MODE_REMOVE, 16'h0000, 16'h0010);
        send_request(MODE_LOOKUP, 16'h0000, 16'hffff);
        send_request(MODE_UNUSED, 16'h0005, 16'h0003);
        // zero-count entry, then fill the table and add one more
        send_request(MODE_ADD,    16'h0001, 16'h0000);
        for (int i = 1; i < 16; i++) begin
            send_request(MODE_ADD, key_pool[i], 16'(i));
        end
        send_request(MODE_ADD,    16'h7777, 16'h0003);

        repeat (170) send_random_request();
        in_idle_pct   = 75;
        out_stall_pct <= 11;
        repeat (170) send_random_request();
        in_idle_pct   = 0;
        out_stall_pct <= 0;
        repeat (160) send_random_request();
        i_in_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (TABLE_ENTRIES + 4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[keyed_count_table_core] OK");
        end else begin
            $display("[keyed_count_table_core] ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[keyed_count_table_core] ERROR");
        $finish;
    end

endmodule
